// ===== rtl/itoa_pkg.sv =====
// Package for the signed integer to decimal ASCII converter.
// Holds character codes, the digit count function and the command and status types.
// No dependencies.
package itoa_pkg;

	// Default width of the signed input value.
	localparam int DEFAULT_VALUE_WIDTH = 32;

	// ASCII codes that the converter emits.
	localparam logic [6:0] CHAR_ZERO  = 7'd48;
	localparam logic [6:0] CHAR_MINUS = 7'd45;

	// Number of decimal digits needed for any magnitude of a w-bit value.
	// The factor 1233/4096 approximates log10(2) from below closely enough
	// for every width from 8 to 64.
	function automatic int num_digits(input int w);
		return ((w * 1233) >> 12) + 1;
	endfunction

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // capture the sign and magnitude of the input
		logic conv;       // one shift-and-add-3 step
		logic shift;      // move to the next digit
		logic emit_digit; // register the top digit as a character
		logic emit_sign;  // register a minus sign as a character
		logic last;       // the emitted digit ends the text
	} itoa_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic neg;      // the captured value is negative
		logic top_zero; // the top decimal digit is zero
	} itoa_status_t;

endpackage

// ===== rtl/itoa_dp.sv =====
// Datapath of the decimal ASCII converter: magnitude, BCD register and result register.
// Depends on itoa_pkg.
module itoa_dp
	import itoa_pkg::*;
#(
	parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
	input  logic                   clk,
	input  logic [VALUE_WIDTH-1:0] value,
	input  itoa_cmd_t              cmd,
	output itoa_status_t           status,
	output logic [6:0]             character,
	output logic                   last
);

	localparam int NDIG = num_digits(VALUE_WIDTH);
	localparam int BW   = NDIG * 4;

	logic [VALUE_WIDTH-1:0] mag_q;
	logic [BW-1:0]          bcd_q;
	logic                   neg_q;
	logic [6:0]             char_q;
	logic                   last_q;
	logic [BW-1:0]          bcd_adj;
	logic [3:0]             top_digit;

	// Add three to every BCD digit of five or more before the shift.
	always_comb begin
		for (int d = 0; d < NDIG; d++) begin
			if (bcd_q[d*4 +: 4] >= 4'd5) begin
				bcd_adj[d*4 +: 4] = bcd_q[d*4 +: 4] + 4'd3;
			end else begin
				bcd_adj[d*4 +: 4] = bcd_q[d*4 +: 4];
			end
		end
	end

	assign top_digit = bcd_q[BW-1 -: 4];

	// Sign and magnitude capture, binary to BCD steps and digit walk.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= value[VALUE_WIDTH-1];
			mag_q <= value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
			bcd_q <= '0;
		end else if (cmd.conv) begin
			{bcd_q, mag_q} <= {bcd_adj[BW-2:0], mag_q, 1'b0};
		end else if (cmd.shift) begin
			bcd_q <= {bcd_q[BW-5:0], 4'd0};
		end
	end

	// Result register, one character per emit command.
	always_ff @(posedge clk) begin
		if (cmd.emit_sign) begin
			char_q <= CHAR_MINUS;
			last_q <= 1'b0;
		end else if (cmd.emit_digit) begin
			char_q <= CHAR_ZERO + {3'd0, top_digit};
			last_q <= cmd.last;
		end
	end

	assign status.neg      = neg_q;
	assign status.top_zero = (top_digit == 4'd0);
	assign character       = char_q;
	assign last            = last_q;

endmodule

// ===== rtl/itoa_ctrl.sv =====
// Controller of the decimal ASCII converter: sequences conversion and character output.
// Depends on itoa_pkg.
module itoa_ctrl
	import itoa_pkg::*;
#(
	parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	output logic         strobe,
	output itoa_cmd_t    cmd,
	input  itoa_status_t status
);

	localparam int NDIG = num_digits(VALUE_WIDTH);
	localparam int CW   = $clog2(VALUE_WIDTH);
	localparam int DW   = $clog2(NDIG + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CONV,
		S_SIGN,
		S_DIGITS
	} state_t;

	state_t        state_q;
	logic [CW-1:0] conv_cnt_q;
	logic [DW-1:0] digit_cnt_q;
	logic          lead_q;
	logic          strobe_q;
	logic          skip;
	logic          final_digit;

	// A leading zero is skipped unless it is the only digit left.
	assign final_digit = (digit_cnt_q == DW'(1));
	assign skip        = lead_q && status.top_zero && !final_digit;

	// Commands decoded from the state.
	always_comb begin
		cmd            = '0;
		cmd.load       = (state_q == S_IDLE) && start;
		cmd.conv       = (state_q == S_CONV);
		cmd.emit_sign  = (state_q == S_SIGN);
		cmd.shift      = (state_q == S_DIGITS);
		cmd.emit_digit = (state_q == S_DIGITS) && !skip;
		cmd.last       = final_digit;
	end

	// State, counters and the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			conv_cnt_q  <= '0;
			digit_cnt_q <= '0;
			lead_q      <= 1'b0;
			strobe_q    <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						conv_cnt_q <= '0;
						state_q    <= S_CONV;
					end
				end
				S_CONV: begin
					conv_cnt_q <= conv_cnt_q + 1'b1;
					if (conv_cnt_q == CW'(VALUE_WIDTH - 1)) begin
						digit_cnt_q <= DW'(NDIG);
						lead_q      <= 1'b1;
						state_q     <= status.neg ? S_SIGN : S_DIGITS;
					end
				end
				S_SIGN: begin
					strobe_q <= 1'b1;
					state_q  <= S_DIGITS;
				end
				S_DIGITS: begin
					digit_cnt_q <= digit_cnt_q - 1'b1;
					if (!skip) begin
						lead_q   <= 1'b0;
						strobe_q <= 1'b1;
					end
					if (final_digit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign strobe = strobe_q;

`ifndef SYNTHESIS
	// A result only follows a cycle that emitted a sign or a digit.
	a_strobe_source: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q |-> ($past(state_q) == S_SIGN || $past(state_q) == S_DIGITS))
		else $error("strobe without an emitting cycle");

	// The digit walk never runs past its last digit.
	a_digit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIGITS) |-> (digit_cnt_q != '0))
		else $error("digit counter empty in digit phase");

	// The final digit is always emitted and ends the transaction sequence.
	a_final_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIGITS && final_digit) |-> (cmd.emit_digit && cmd.last))
		else $error("final digit not emitted as last");

	// The sign goes out only for a negative value, right after conversion.
	a_sign_after_conv: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SIGN) |-> ($past(state_q) == S_CONV && status.neg))
		else $error("sign emitted out of sequence");
`endif

endmodule

// ===== rtl/signed_int_to_decimal_ascii.sv =====
// Signed integer to decimal ASCII converter, top level.
// The first character is strobed after all binary to BCD steps: the sign for a negative value,
// else the first digit that is not a skipped leading zero.
// An item keeps busy high through one binary to BCD step per magnitude bit, a sign step for a
// negative value and one step per digit.
// Characters come one per cycle without gaps except for skipped leading zeros.
// Reset is asynchronous and active low; it returns the controller to idle with no strobe.
module signed_int_to_decimal_ascii
	import itoa_pkg::*;
#(
	parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [VALUE_WIDTH-1:0] value,
	output logic                   strobe,
	output logic [6:0]             character,
	output logic                   last
);

	itoa_cmd_t    cmd;
	itoa_status_t status;

	// Sequencing of conversion and output.
	itoa_ctrl #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.strobe (strobe),
		.cmd    (cmd),
		.status (status)
	);

	// Magnitude, BCD digits and result register.
	itoa_dp #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_dp (
		.clk       (clk),
		.value     (value),
		.cmd       (cmd),
		.status    (status),
		.character (character),
		.last      (last)
	);

endmodule

// ===== verif/signed_int_to_decimal_ascii_checker.sv =====
// Checker for the signed integer to decimal ASCII converter.
// Watches the command and character channels, predicts the text and compares it.
// Depends on itoa_pkg for the character codes and the default width.
`timescale 1ns / 1ps

module itoa_text_checker
	import itoa_pkg::*;
#(
	parameter int W = DEFAULT_VALUE_WIDTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic         busy,
	input  logic [W-1:0] value,
	input  logic         strobe,
	input  logic [6:0]   character,
	input  logic         last,
	output int           errors,
	output int           outstanding
);

	// One expected character of the decimal text.
	typedef struct packed {
		logic [6:0] code;
		logic       is_last;
	} text_char_t;

	text_char_t expected_chars [$];
	int         error_count;

	// Append the decimal text of one signed value to the expected characters.
	function automatic void predict_text(input logic [W-1:0] v);
		logic [W-1:0] magnitude;
		logic [63:0]  rest;
		logic [3:0]   digit_stack [24];
		int           n;
		n = 0;
		magnitude = v[W-1] ? (~v + 1'b1) : v;
		rest = 64'(magnitude);
		do begin
			digit_stack[n] = 4'(rest % 10);
			n++;
			rest = rest / 10;
		end while (rest != 0);
		if (v[W-1]) begin
			expected_chars.push_back('{code: CHAR_MINUS, is_last: 1'b0});
		end
		for (int i = n - 1; i >= 0; i--) begin
			expected_chars.push_back('{code: 7'(CHAR_ZERO + digit_stack[i]), is_last: (i == 0)});
		end
	endfunction

	// Predict on each accepted command transaction and check each strobed character.
	always @(posedge clk) begin
		text_char_t exp_char;
		if (arst_n) begin
			if (strobe) begin
				if (expected_chars.size() == 0) begin
					error_count++;
					if (error_count <= 10) begin
						$display("unexpected character %0d last %0b", character, last);
					end
				end else begin
					exp_char = expected_chars.pop_front();
					if (character !== exp_char.code || last !== exp_char.is_last) begin
						error_count++;
						if (error_count <= 10) begin
							$display("mismatch: expected character %0d last %0b, got %0d last %0b",
								exp_char.code, exp_char.is_last, character, last);
						end
					end
				end
			end
			if (start && !busy) begin
				predict_text(value);
			end
		end
		errors <= error_count;
		outstanding <= expected_chars.size();
	end

endmodule

// ===== verif/testbench.sv =====
// Top of the testbench for the signed integer to decimal ASCII converter.
// Drives directed and random conversion commands and reports the verdict.
// Depends on itoa_pkg, signed_int_to_decimal_ascii and itoa_text_checker.
`timescale 1ns / 1ps

module testbench;
	import itoa_pkg::*;

	localparam int W = DEFAULT_VALUE_WIDTH;
	localparam int CYCLE_LIMIT = 400000;

	logic         clk;
	logic         arst_n;
	logic         start;
	logic         busy;
	logic [W-1:0] value;
	logic         strobe;
	logic [6:0]   character;
	logic         last;
	int           errors;
	int           outstanding;
	int           idle_pct;
	int           cycle_count;

	signed_int_to_decimal_ascii #(.VALUE_WIDTH(W)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.value     (value),
		.strobe    (strobe),
		.character (character),
		.last      (last)
	);

	itoa_text_checker #(.W(W)) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.value       (value),
		.strobe      (strobe),
		.character   (character),
		.last        (last),
		.errors      (errors),
		.outstanding (outstanding)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Issue one conversion transaction, with random idle cycles in front of it.
	// Called at a falling edge and returns at a falling edge.
	task automatic send_value(input logic [W-1:0] v);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		value <= v;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	// Wait until every expected character has come back.
	task automatic drain_text();
		start <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
	endtask

	// Random value: full range, a random number of decades, or near zero.
	function automatic logic [W-1:0] random_value();
		logic [W-1:0] mag;
		int unsigned  decade;
		int unsigned  k;
		case ($urandom_range(0, 3))
			0, 1: begin
				mag = $urandom;
				return mag;
			end
			2: begin
				decade = 1;
				k = $urandom_range(0, 9);
				for (int i = 0; i < k; i++) decade = decade * 10;
				mag = $urandom_range(0, (decade > 1) ? decade * 2 - 1 : 9);
			end
			default: mag = $urandom_range(0, 20);
		endcase
		if ($urandom_range(0, 1)) mag = ~mag + 1'b1;
		return mag;
	endfunction

	logic [W-1:0] directed_values [] = '{
		32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100, -32'sd100,
		32'd2147483647, 32'h8000_0000, -32'sd2147483647, 32'd1000000000, 32'd999999999,
		-32'sd999999999, 32'd1234567890, -32'sd1234567890, 32'h5555_5555, 32'hAAAA_AAAA,
		32'd1000000001, -32'sd1000000000, 32'd7, -32'sd8
	};

	int phase_pct [4] = '{0, 51, 0, 35};

	// Stimulus and verdict.
	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		value = '0;
		idle_pct = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed values: extremes, digit count boundaries and the most negative value.
		foreach (directed_values[i]) send_value(directed_values[i]);
		drain_text();

		// Random values over several idling phases, pausing for all results between phases.
		foreach (phase_pct[p]) begin
			idle_pct = phase_pct[p];
			repeat (20) send_value(random_value());
			drain_text();
		end

		repeat (60) @(negedge clk);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
